@@ hdl/sha_pkg.sv @@
// Package for the SHA-256 byte stream hasher: payload structs, state enum,
// round constants, initial hash values and round helper functions.
// Depends on nothing.
package sha_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_EMIT
    } state_t;

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        begin
            case (idx)
                6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491;
                6'd2: k = 32'hb5c0fbcf; 6'd3: k = 32'he9b5dba5;
                6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
                6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5;
                6'd8: k = 32'hd807aa98; 6'd9: k = 32'h12835b01;
                6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

    function automatic logic [31:0] init_h(input logic [2:0] idx);
        logic [31:0] h;
        begin
            case (idx)
                3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
                3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
                3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
                3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
                default: h = 32'h0;
            endcase
            return h;
        end
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] v, input int amt);
        return (v >> amt) | (v << (32 - amt));
    endfunction

endpackage

@@ hdl/sha256_byte_stream_hasher.sv @@
// Top level of the SHA-256 byte stream hasher: block word memory, padding
// sequencer and digest output. Depends on sha_pkg and sha_core.
//
//   channel   direction  payload              handshake
//   in        input      sha_pkg::in_word_t   in_valid / in_ready
//   out       output     sha_pkg::out_word_t  out_valid / out_ready
//
// An input word is taken in the idle state. A full block is then loaded and
// compressed before the next word is taken. A last word adds one padded
// block, or two when 56 or more bytes sit in the final partial block, and
// then eight output words, each held until out_ready takes it.
// Reset restores the initial hash values and clears the byte count.
// The input is held off during loading and compression and while the digest goes out.
module sha256_byte_stream_hasher (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  sha_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output sha_pkg::out_word_t out_data
);

    logic [31:0] blk_mem [16];
    logic [31:0] rd_reg;
    logic [60:0] len_reg, len_next;
    sha_pkg::state_t state_reg, state_next;
    logic [4:0]  ld_reg, ld_next;
    logic        last_reg, last_next;
    logic        pad_reg, pad_next;
    logic        extra_reg, extra_next;
    logic [2:0]  oi_reg, oi_next;

    logic        accept;
    logic        wr_en;
    logic [5:0]  pos;
    logic [63:0] bits;
    logic        fin_blk;
    logic [3:0]  load_addr;
    logic [31:0] load_word;
    logic        start, load_en, chain_init, core_busy, core_done;
    logic [31:0] chain_out;

    // Padded blocks take 0x80, zero fill and the bit length in place of stored bytes.
    function automatic logic [31:0] fill_word(input logic [31:0] d, input logic [3:0] wa,
                                              input logic [5:0] p, input logic pad,
                                              input logic ex, input logic fin,
                                              input logic [63:0] b);
        logic [31:0] r;
        logic [5:0]  a;
        logic [7:0]  v;
        begin
            r = d;
            for (int i = 0; i < 4; i++)
            begin
                a = {wa, 2'(i)};
                v = d[8 * (3 - i) +: 8];
                if (pad)
                begin
                    if (ex || a > p)
                        v = 8'h00;
                    else if (a == p)
                        v = 8'h80;
                    if (fin && a >= 6'd56)
                        v = b[{~a[2:0], 3'b000} +: 8];
                end
                r[8 * (3 - i) +: 8] = v;
            end
            return r;
        end
    endfunction

    assign accept    = in_valid && in_ready;
    assign pos       = len_reg[5:0];
    assign bits      = {len_reg, 3'b000};
    assign fin_blk   = extra_reg || (pos < 6'd56);
    assign load_addr = ld_reg[3:0] - 4'd1;
    assign load_word = fill_word(rd_reg, load_addr, pos, pad_reg, extra_reg, fin_blk, bits);

    always_comb
    begin
        state_next = state_reg;
        len_next   = len_reg;
        ld_next    = ld_reg;
        last_next  = last_reg;
        pad_next   = pad_reg;
        extra_next = extra_reg;
        oi_next    = oi_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        wr_en      = 1'b0;
        start      = 1'b0;
        load_en    = 1'b0;
        chain_init = 1'b0;
        case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    last_next = in_data.last_byte;
                    if (in_data.has_byte)
                    begin
                        wr_en    = 1'b1;
                        len_next = len_reg + 61'd1;
                    end
                    if (in_data.has_byte && pos == 6'd63)
                    begin
                        state_next = sha_pkg::ST_LOAD;
                        ld_next    = 5'd0;
                        pad_next   = 1'b0;
                    end
                    else if (in_data.last_byte)
                    begin
                        state_next = sha_pkg::ST_LOAD;
                        ld_next    = 5'd0;
                        pad_next   = 1'b1;
                        extra_next = 1'b0;
                    end
                end
            end
            sha_pkg::ST_LOAD:
            begin
                // The memory read is registered, so its word arrives in the cycle after the address.
                ld_next = ld_reg + 5'd1;
                load_en = (ld_reg != 5'd0);
                if (ld_reg == 5'd16)
                begin
                    start      = 1'b1;
                    state_next = sha_pkg::ST_ROUND;
                end
            end
            sha_pkg::ST_ROUND:
            begin
                if (core_done)
                begin
                    if (!last_reg)
                    begin
                        state_next = sha_pkg::ST_IDLE;
                    end
                    else if (!pad_reg)
                    begin
                        state_next = sha_pkg::ST_LOAD;
                        ld_next    = 5'd0;
                        pad_next   = 1'b1;
                        extra_next = 1'b0;
                    end
                    else if (!fin_blk)
                    begin
                        state_next = sha_pkg::ST_LOAD;
                        ld_next    = 5'd0;
                        extra_next = 1'b1;
                    end
                    else
                    begin
                        state_next = sha_pkg::ST_EMIT;
                        oi_next    = 3'd0;
                    end
                end
            end
            sha_pkg::ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    oi_next = oi_reg + 3'd1;
                    if (oi_reg == 3'd7)
                    begin
                        chain_init = 1'b1;
                        len_next   = 61'd0;
                        last_next  = 1'b0;
                        pad_next   = 1'b0;
                        extra_next = 1'b0;
                        state_next = sha_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sha_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha_pkg::ST_IDLE;
            len_reg   <= 61'd0;
            ld_reg    <= 5'd0;
            last_reg  <= 1'b0;
            pad_reg   <= 1'b0;
            extra_reg <= 1'b0;
            oi_reg    <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            ld_reg    <= ld_next;
            last_reg  <= last_next;
            pad_reg   <= pad_next;
            extra_reg <= extra_next;
            oi_reg    <= oi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            blk_mem[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= in_data.data_byte;
        end
        rd_reg <= blk_mem[ld_reg[3:0]];
    end

    sha_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .load_en    (load_en),
        .load_addr  (load_addr),
        .load_data  (load_word),
        .chain_init (chain_init),
        .chain_sel  (oi_reg),
        .chain_out  (chain_out),
        .busy       (core_busy),
        .done       (core_done)
    );

    assign out_data.digest_word = chain_out;
    assign out_data.word_index  = oi_reg;
    assign out_data.last_word   = (oi_reg == 3'd7);

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !core_busy) else $error("input taken while core runs");
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_reg == sha_pkg::ST_EMIT) else $error("stray output");
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && oi_reg == 3'd7) |=> !out_valid)
        else $error("extra digest word");

endmodule

@@ hdl/sha_core.sv @@
// SHA-256 compression core: 16-entry schedule memory, one round per cycle.
// Depends on sha_pkg. Loads 16 words, runs 64 rounds, folds into chain.
module sha_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        load_en,
    input  logic [3:0]  load_addr,
    input  logic [31:0] load_data,
    input  logic        chain_init,
    input  logic [2:0]  chain_sel,
    output logic [31:0] chain_out,
    output logic        busy,
    output logic        done
);

    logic [31:0] sched_mem [16];
    logic [31:0] chain_reg [8];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg;
    logic [6:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;

    logic [5:0]  rnd;
    logic [31:0] w, w15, w2, w7, w16, s0, s1, t1, t2, wnew;

    // Schedule window is held as a shift line read at fixed taps.
    assign rnd  = cnt_reg[5:0];
    assign w16  = sched_mem[0];
    assign w15  = sched_mem[1];
    assign w7   = sched_mem[9];
    assign w2   = sched_mem[14];
    assign s0   = sha_pkg::rotr(w15, 7) ^ sha_pkg::rotr(w15, 18) ^ (w15 >> 3);
    assign s1   = sha_pkg::rotr(w2, 17) ^ sha_pkg::rotr(w2, 19) ^ (w2 >> 10);
    assign wnew = w16 + s0 + w7 + s1;
    assign w    = (rnd < 6'd16) ? sched_mem[0] : wnew;
    assign t1   = h_reg + (sha_pkg::rotr(e_reg, 6) ^ sha_pkg::rotr(e_reg, 11)
                  ^ sha_pkg::rotr(e_reg, 25)) + ((e_reg & f_reg) ^ (~e_reg & g_reg))
                  + sha_pkg::round_k(rnd) + w;
    assign t2   = (sha_pkg::rotr(a_reg, 2) ^ sha_pkg::rotr(a_reg, 13)
                  ^ sha_pkg::rotr(a_reg, 22))
                  + ((a_reg & b_reg) ^ (a_reg & c_reg) ^ (b_reg & c_reg));

    always_comb
    begin
        run_next  = run_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = 7'd0;
        end
        else if (run_reg)
        begin
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd64)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= 7'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            sched_mem[load_addr] <= load_data;
        end
        else if (run_reg && cnt_reg < 7'd64)
        begin
            for (int i = 0; i < 15; i++)
            begin
                sched_mem[i] <= sched_mem[i + 1];
            end
            sched_mem[15] <= w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= sha_pkg::init_h(3'(i));
            end
        end
        else if (chain_init)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= sha_pkg::init_h(3'(i));
            end
        end
        else if (run_reg && cnt_reg == 7'd64)
        begin
            chain_reg[0] <= chain_reg[0] + a_reg;
            chain_reg[1] <= chain_reg[1] + b_reg;
            chain_reg[2] <= chain_reg[2] + c_reg;
            chain_reg[3] <= chain_reg[3] + d_reg;
            chain_reg[4] <= chain_reg[4] + e_reg;
            chain_reg[5] <= chain_reg[5] + f_reg;
            chain_reg[6] <= chain_reg[6] + g_reg;
            chain_reg[7] <= chain_reg[7] + h_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= chain_reg[0]; b_reg <= chain_reg[1];
            c_reg <= chain_reg[2]; d_reg <= chain_reg[3];
            e_reg <= chain_reg[4]; f_reg <= chain_reg[5];
            g_reg <= chain_reg[6]; h_reg <= chain_reg[7];
        end
        else if (run_reg && cnt_reg < 7'd64)
        begin
            h_reg <= g_reg; g_reg <= f_reg; f_reg <= e_reg; e_reg <= d_reg + t1;
            d_reg <= c_reg; c_reg <= b_reg; b_reg <= a_reg; a_reg <= t1 + t2;
        end
    end

    assign chain_out = chain_reg[chain_sel];
    assign busy      = run_reg;
    assign done      = done_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !run_reg) else $error("start while busy");
    a_done_after: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !run_reg) else $error("done while running");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        load_en |-> !run_reg) else $error("load while running");

endmodule
